// ===== rtl/core/smqa_pkg.sv =====
// smqa_pkg: shared types and constants of the memory quota admission engine.
// No dependencies.
package smqa_pkg;

	localparam int unsigned BW = 48;
	localparam logic [BW-1:0] M48 = {BW{1'b1}};
	localparam logic [BW-1:0] MIN_CLIENT_BYTES = 48'd131072;
	localparam logic [6:0] PCT_FULL = 7'd100;

	localparam logic [3:0] KIND_RESERVE   = 4'd0;
	localparam logic [3:0] KIND_RELEASE   = 4'd1;
	localparam logic [3:0] KIND_COMMIT    = 4'd2;
	localparam logic [3:0] KIND_CHARGE    = 4'd3;
	localparam logic [3:0] KIND_UNCHARGE  = 4'd4;
	localparam logic [3:0] KIND_FS_RSV    = 4'd5;
	localparam logic [3:0] KIND_FS_USE    = 4'd6;
	localparam logic [3:0] KIND_FS_RST    = 4'd7;
	localparam logic [3:0] KIND_FS_REL    = 4'd8;
	localparam logic [3:0] KIND_CL_ACQ    = 4'd9;
	localparam logic [3:0] KIND_CL_REL    = 4'd10;
	localparam logic [3:0] KIND_QUERY     = 4'd11;
	localparam logic [3:0] KIND_REFRESH   = 4'd12;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DENIED = 2'd1;
	localparam logic [1:0] ST_FAULT  = 2'd2;

	localparam logic [2:0] REG_MAX_BYTES = 3'd0;
	localparam logic [2:0] REG_WORKERS   = 3'd1;
	localparam logic [2:0] REG_CL_VALUE  = 3'd2;
	localparam logic [2:0] REG_CL_PCT    = 3'd3;

	typedef struct packed {
		logic [3:0]    kind;
		logic [6:0]    shard;
		logic [BW-1:0] amount;
		logic [BW-1:0] retained_amount;
	} item_t;

	// classified event: item plus resolved shard
	typedef struct packed {
		item_t      item;
		logic [6:0] shard_eff;
	} cls_t;

	typedef struct packed {
		logic [BW-1:0] max_bytes;
		logic [6:0]    workers;
		logic [BW-1:0] cl_value;
		logic          cl_pct;
	} cfg_t;

endpackage

// ===== rtl/core/smqa_if.sv =====
// smqa_if: handshake channel interfaces for events, results and config writes.
// Depends on smqa_pkg.
interface smqa_item_if;
	import smqa_pkg::*;
	logic          valid;
	logic          ready;
	logic [3:0]    kind;
	logic [6:0]    shard;
	logic [BW-1:0] amount;
	logic [BW-1:0] retained_amount;
	modport source(output valid, kind, shard, amount, retained_amount, input ready);
	modport sink(input valid, kind, shard, amount, retained_amount, output ready);
endinterface

interface smqa_result_if;
	import smqa_pkg::*;
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic [BW-1:0] used_bytes;
	logic [BW-1:0] peak_used_bytes;
	logic [BW-1:0] pending_total;
	logic [BW-1:0] fullsync_total;
	logic [BW-1:0] client_total;
	logic [BW-1:0] client_limit_bytes;
	modport source(output valid, status, used_bytes, peak_used_bytes, pending_total,
		fullsync_total, client_total, client_limit_bytes, input ready);
	modport sink(input valid, status, used_bytes, peak_used_bytes, pending_total,
		fullsync_total, client_total, client_limit_bytes, output ready);
endinterface

interface smqa_cfg_if;
	import smqa_pkg::*;
	logic          valid;
	logic          ready;
	logic [2:0]    index;
	logic [BW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/sharded_memory_quota_admission.sv =====
// sharded_memory_quota_admission: top level, config registers, front queue and
// back sequencer. Depends on smqa_pkg, smqa_if, smqa_front, smqa_back, smqa_div.
//
//   channel | dir | payload
//   cfg     | in  | index, data (register write)
//   item    | in  | kind, shard, amount, retained_amount
//   result  | out | status, used/peak, pending/fullsync/client totals, client limit
//
// One event at a time: one divide-by-ten pass for the steady limit (two more
// for a percent client limit), three divisions by W on the bit-serial divider
// for a worker shard, plus a sum over the W+1 shards before and after the
// counter update, and control states.
// Reset clears all counters and gauges; config returns to its defaults.
// A two-entry queue accepts events while a result waits to be taken, until it is full.
module sharded_memory_quota_admission #(
	parameter int unsigned MAX_WORKERS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	smqa_cfg_if.sink      cfg,
	smqa_item_if.sink     item,
	smqa_result_if.source result
);
	import smqa_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid, q_pop;
	cls_t  q_data;
	logic [6:0] wclamp;

	assign cfg.ready = 1'b1;
	assign wclamp = (cfg_q.workers > 7'(MAX_WORKERS)) ? 7'(MAX_WORKERS) : cfg_q.workers;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_bytes <= '0;
			cfg_q.workers   <= 7'd1;
			cfg_q.cl_value  <= 48'd5;
			cfg_q.cl_pct    <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_BYTES: cfg_q.max_bytes <= cfg.data;
				REG_WORKERS:   cfg_q.workers   <= cfg.data[6:0];
				REG_CL_VALUE:  cfg_q.cl_value  <= cfg.data;
				REG_CL_PCT:    cfg_q.cl_pct    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	smqa_front u_front (
		.clk(clk), .arst_n(arst_n), .item(item), .workers(wclamp),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	smqa_back #(.MAX_WORKERS(MAX_WORKERS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid),
		.q_data(q_data), .q_pop(q_pop), .result(result)
	);

	a_peak_ge_used: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.peak_used_bytes >= result.used_bytes)
		else $error("peak below used gauge");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.status != 2'd3)
		else $error("bad status code");

	a_client_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.client_limit_bytes == '0 ||
		result.client_limit_bytes >= MIN_CLIENT_BYTES))
		else $error("client limit below floor");
endmodule

// ===== rtl/core/smqa_div.sv =====
// smqa_div: restoring divider, one quotient bit per cycle, 56-bit by 7-bit, and
// smqa_div10: multi-cycle shift-add divide by ten of a 56-bit value. No dependencies.
module smqa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [55:0] dividend,
	input  logic [6:0]  divisor,
	output logic        done,
	output logic [55:0] quot,
	output logic [6:0]  rem
);
	logic [55:0] n_q;
	logic [6:0]  r_q;
	logic [6:0]  d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  shifted;
	logic        ge;

	assign shifted = {r_q, n_q[55]};
	assign ge = shifted >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd56;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			n_q <= {n_q[54:0], ge};
			r_q <= ge ? 7'(shifted - {1'b0, d_q}) : shifted[6:0];
		end
	end

	assign done = done_q;
	assign quot = n_q;
	assign rem  = r_q;
endmodule

// reciprocal approximation by shifted adds, then one remainder correction
module smqa_div10 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [55:0] dividend,
	output logic        done,
	output logic [55:0] quot
);
	logic [55:0] n_q;
	logic [55:0] t_q;
	logic [55:0] r_q;
	logic [2:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [55:0] rem;

	assign rem = n_q - ((t_q << 3) + (t_q << 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
		end else if (busy_q) begin
			case (step_q)
				3'd0: t_q <= (n_q >> 1) + (n_q >> 2);
				3'd1: t_q <= t_q + (t_q >> 4);
				3'd2: t_q <= t_q + (t_q >> 8);
				3'd3: t_q <= t_q + (t_q >> 16);
				3'd4: t_q <= t_q + (t_q >> 32);
				3'd5: t_q <= t_q >> 3;
				3'd6: r_q <= rem;
				default: t_q <= t_q + {55'b0, (r_q > 56'd9)};
			endcase
		end
	end

	assign done = done_q;
	assign quot = t_q;
endmodule

// ===== rtl/core/smqa_front.sv =====
// smqa_front: accepts events, resolves the shard, queues up to two classified entries.
// Depends on smqa_pkg, smqa_if.
module smqa_front (
	input  logic                clk,
	input  logic                arst_n,
	smqa_item_if.sink           item,
	input  logic [6:0]          workers,
	output logic                q_valid,
	output smqa_pkg::cls_t      q_data,
	input  logic                q_pop
);
	import smqa_pkg::*;

	cls_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	cls_t       cls;

	always_comb begin
		cls.item.kind            = item.kind;
		cls.item.shard           = item.shard;
		cls.item.amount          = item.amount;
		cls.item.retained_amount = item.retained_amount;
		cls.shard_eff = (item.shard >= 7'd1 && item.shard <= workers) ? item.shard : 7'd0;
	end

	assign item.ready = cnt_q != 2'd2;
	assign push = item.valid && item.ready;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= cls;
	end
endmodule

// ===== rtl/core/smqa_back.sv =====
// smqa_back: sequencer owning the shard counters; runs divisions, shard sums,
// the admission checks and the counter update, then holds the result.
// Depends on smqa_pkg, smqa_if, smqa_div, smqa_div10.
module smqa_back #(
	parameter int unsigned MAX_WORKERS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smqa_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  smqa_pkg::cls_t     q_data,
	output logic               q_pop,
	smqa_result_if.source      result
);
	import smqa_pkg::*;

	localparam int unsigned NSH = MAX_WORKERS + 1;
	localparam int unsigned IW = (NSH > 1) ? $clog2(NSH) : 1;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_DIV10 = 12'b000000000010,
		S_CLIM  = 12'b000000000100,
		S_CLIM2 = 12'b000000001000,
		S_SUM0  = 12'b000000010000,
		S_RD0   = 12'b000000100000,
		S_CAP   = 12'b000001000000,
		S_SHR   = 12'b000010000000,
		S_CSH   = 12'b000100000000,
		S_EXEC  = 12'b001000000000,
		S_SUM1  = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [BW-1:0] ret_q  [NSH];
	logic [BW-1:0] pend_q [NSH];
	logic [BW-1:0] fs_q   [NSH];
	logic [BW-1:0] cli_q  [NSH];

	item_t         it_q;
	logic [IW-1:0] s_q;
	logic [IW-1:0] idx_q;
	logic [BW-1:0] steady_q, climit_q, r0_q, cap_q, shr_q, csh_q;
	logic [BW-1:0] acc_ret_q, acc_pend_q, acc_fs_q, acc_cli_q;
	logic [BW-1:0] used_q, peak_q;
	logic [1:0]    st_q;
	logic          out_valid_q;

	logic          div_start_q;
	logic          d10_start_q;
	logic [55:0]   div_n_q;
	logic [6:0]    div_d_q;
	logic          div_done;
	logic [55:0]   div_quot;
	logic [6:0]    div_rem;
	logic          d10_done;
	logic [55:0]   d10_quot;

	logic [IW-1:0] wlim;
	logic [6:0]    wclamp;
	logic [6:0]    shard_id;
	logic [BW-1:0] share_res;
	logic [6:0]    pct;
	logic [54:0]   pct_prod;

	smqa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(div_n_q),
		.divisor(div_d_q), .done(div_done), .quot(div_quot), .rem(div_rem)
	);

	smqa_div10 u_div10 (
		.clk(clk), .arst_n(arst_n), .start(d10_start_q), .dividend(div_n_q),
		.done(d10_done), .quot(d10_quot)
	);

	assign wclamp = (cfg.workers > 7'(MAX_WORKERS)) ? 7'(MAX_WORKERS) : cfg.workers;
	assign wlim = wclamp[IW-1:0];
	assign shard_id = 7'(s_q) - 7'd1;
	assign share_res = div_quot[BW-1:0] + {{(BW-1){1'b0}}, (shard_id < div_rem)};
	assign pct = (cfg.cl_value > 48'(PCT_FULL)) ? PCT_FULL : cfg.cl_value[6:0];
	assign pct_prod = {7'b0, cfg.max_bytes} * {48'b0, pct};

	// saturating shard sums
	function automatic logic [BW-1:0] sat_add(input logic [BW-1:0] x, input logic [BW-1:0] y);
		logic [BW:0] t;
		t = {1'b0, x} + {1'b0, y};
		return t[BW] ? M48 : t[BW-1:0];
	endfunction

	// event evaluation at shard s_q (idx_q == s_q during S_EXEC)
	logic [BW-1:0] rr, rp, rf, rc, a, ra;
	logic [BW+2:0] chk_sum;
	logic          exceed;
	logic          cl_deny;
	logic [1:0]    st_n;
	logic          wr_ret, wr_pend, wr_fs, wr_cli;
	logic [BW-1:0] nret, npend, nfs, ncli;

	function automatic logic fits(input logic [BW-1:0] cur, input logic [BW-1:0] add);
		logic [BW:0] t;
		t = {1'b0, cur} + {1'b0, add};
		return !t[BW];
	endfunction

	always_comb begin
		rr = ret_q[idx_q];
		rp = pend_q[idx_q];
		rf = fs_q[idx_q];
		rc = cli_q[idx_q];
		a  = it_q.amount;
		ra = it_q.retained_amount;
		if (s_q == '0) begin
			chk_sum = {3'b0, acc_ret_q} + {3'b0, acc_fs_q} + {3'b0, acc_pend_q} + {3'b0, a};
			exceed = (steady_q != '0) &&
				((acc_ret_q >= steady_q) || (chk_sum > {3'b0, steady_q}));
		end else begin
			chk_sum = {3'b0, shr_q} + {3'b0, rr} + {3'b0, rf} + {3'b0, rp} + {3'b0, a};
			exceed = (steady_q != '0) && ((shr_q >= cap_q) || (chk_sum > {3'b0, cap_q}));
		end
		cl_deny = (cfg.max_bytes != '0) && ((s_q == '0) ||
			((climit_q != '0) && (({1'b0, rc} + {1'b0, a}) > {1'b0, csh_q})));
		st_n = ST_OK;
		wr_ret = 1'b0; wr_pend = 1'b0; wr_fs = 1'b0; wr_cli = 1'b0;
		nret = rr + a; npend = rp + a; nfs = rf + a; ncli = rc + a;
		case (it_q.kind)
			KIND_RESERVE: begin
				if (a != '0 && steady_q != '0) begin
					if (exceed) st_n = ST_DENIED;
					else if (!fits(rp, a)) st_n = ST_FAULT;
					else wr_pend = 1'b1;
				end
			end
			KIND_RELEASE: begin
				npend = rp - a;
				if (rp < a) st_n = ST_FAULT; else wr_pend = 1'b1;
			end
			KIND_COMMIT: begin
				npend = rp - a;
				nret = rr + ra;
				if (rp < a || !fits(rr, ra)) st_n = ST_FAULT;
				else begin wr_pend = 1'b1; wr_ret = 1'b1; end
			end
			KIND_CHARGE: begin
				if (!fits(rr, a)) st_n = ST_FAULT; else wr_ret = 1'b1;
			end
			KIND_UNCHARGE: begin
				nret = rr - a;
				if (rr < a) st_n = ST_FAULT; else wr_ret = 1'b1;
			end
			KIND_FS_RSV: begin
				if (a != '0) begin
					if (exceed) st_n = ST_DENIED;
					else if (!fits(rf, a)) st_n = ST_FAULT;
					else wr_fs = 1'b1;
				end
			end
			KIND_FS_USE: begin
				nfs = rf - a;
				if (rf < a || !fits(rr, a)) st_n = ST_FAULT;
				else begin wr_fs = 1'b1; wr_ret = 1'b1; end
			end
			KIND_FS_RST: begin
				nret = rr - a;
				if (rr < a || !fits(rf, a)) st_n = ST_FAULT;
				else begin wr_fs = 1'b1; wr_ret = 1'b1; end
			end
			KIND_FS_REL: begin
				nfs = rf - a;
				if (rf < a) st_n = ST_FAULT; else wr_fs = 1'b1;
			end
			KIND_CL_ACQ: begin
				if (a != '0) begin
					if (cl_deny) st_n = ST_DENIED;
					else if (!fits(rc, a)) st_n = ST_FAULT;
					else wr_cli = 1'b1;
				end
			end
			KIND_CL_REL: begin
				ncli = rc - a;
				if (rc < a) st_n = ST_FAULT; else wr_cli = 1'b1;
			end
			KIND_QUERY: st_n = exceed ? ST_DENIED : ST_OK;
			default: st_n = ST_OK;
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && q_valid && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			d10_start_q <= 1'b0;
			idx_q       <= '0;
			used_q      <= '0;
			peak_q      <= '0;
			for (int i = 0; i < NSH; i++) begin
				ret_q[i]  <= '0;
				pend_q[i] <= '0;
				fs_q[i]   <= '0;
				cli_q[i]  <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			d10_start_q <= 1'b0;
			if (result.valid && result.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						it_q <= q_data.item;
						s_q  <= q_data.shard_eff[IW-1:0];
						d10_start_q <= 1'b1;
						div_n_q <= {8'b0, cfg.max_bytes};
						state_q <= S_DIV10;
					end
				end
				S_DIV10: begin
					if (d10_done) begin
						steady_q <= cfg.max_bytes - d10_quot[BW-1:0];
						if (cfg.cl_value != '0 && cfg.cl_pct) begin
							d10_start_q <= 1'b1;
							div_n_q <= {1'b0, pct_prod};
							state_q <= S_CLIM;
						end else begin
							climit_q <= (cfg.cl_value == '0) ? '0 :
								((cfg.cl_value < MIN_CLIENT_BYTES) ? MIN_CLIENT_BYTES
								: cfg.cl_value);
							idx_q <= '0;
							acc_ret_q <= '0; acc_pend_q <= '0;
							acc_fs_q <= '0; acc_cli_q <= '0;
							state_q <= S_SUM0;
						end
					end
				end
				// percent limit: two passes of divide by ten
				S_CLIM: begin
					if (d10_done) begin
						d10_start_q <= 1'b1;
						div_n_q <= d10_quot;
						state_q <= S_CLIM2;
					end
				end
				S_CLIM2: begin
					if (d10_done) begin
						climit_q <= (d10_quot[BW-1:0] < MIN_CLIENT_BYTES) ? MIN_CLIENT_BYTES
							: d10_quot[BW-1:0];
						idx_q <= '0;
						acc_ret_q <= '0; acc_pend_q <= '0;
						acc_fs_q <= '0; acc_cli_q <= '0;
						state_q <= S_SUM0;
					end
				end
				S_SUM0, S_SUM1: begin
					acc_ret_q  <= sat_add(acc_ret_q, ret_q[idx_q]);
					acc_pend_q <= sat_add(acc_pend_q, pend_q[idx_q]);
					acc_fs_q   <= sat_add(acc_fs_q, fs_q[idx_q]);
					acc_cli_q  <= sat_add(acc_cli_q, cli_q[idx_q]);
					if (idx_q == wlim) begin
						idx_q <= '0;
						state_q <= (state_q == S_SUM0) ? S_RD0 : S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_RD0: begin
					r0_q <= ret_q[idx_q];
					if (s_q != '0) begin
						div_start_q <= 1'b1;
						div_n_q <= {8'b0, steady_q};
						div_d_q <= wclamp;
						state_q <= S_CAP;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_CAP: begin
					if (div_done) begin
						cap_q <= share_res;
						div_start_q <= 1'b1;
						div_n_q <= {8'b0, r0_q};
						div_d_q <= wclamp;
						state_q <= S_SHR;
					end
				end
				S_SHR: begin
					if (div_done) begin
						shr_q <= share_res;
						div_start_q <= 1'b1;
						div_n_q <= {8'b0, climit_q};
						div_d_q <= wclamp;
						state_q <= S_CSH;
					end
				end
				S_CSH: begin
					if (div_done) begin
						csh_q <= share_res;
						idx_q <= s_q;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q <= st_n;
					if (wr_ret)  ret_q[idx_q]  <= nret;
					if (wr_pend) pend_q[idx_q] <= npend;
					if (wr_fs)   fs_q[idx_q]   <= nfs;
					if (wr_cli)  cli_q[idx_q]  <= ncli;
					if (it_q.kind == KIND_REFRESH) begin
						used_q <= acc_ret_q;
						if (acc_ret_q > peak_q) peak_q <= acc_ret_q;
					end
					idx_q <= '0;
					acc_ret_q <= '0; acc_pend_q <= '0;
					acc_fs_q <= '0; acc_cli_q <= '0;
					state_q <= S_SUM1;
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid              = out_valid_q;
	assign result.status             = st_q;
	assign result.used_bytes         = used_q;
	assign result.peak_used_bytes    = peak_q;
	assign result.pending_total      = acc_pend_q;
	assign result.fullsync_total     = acc_fs_q;
	assign result.client_total       = acc_cli_q;
	assign result.client_limit_bytes = climit_q;
endmodule

// ===== sim/smqa_tb_if.sv =====
// Testbench-side notes: the channel interfaces come from the RTL (smqa_if.sv).
// This file holds the shared quota result type used by the testbench top.
// Depends on smqa_pkg.
`timescale 1ns / 100ps
package smqa_tb_pkg;
	import smqa_pkg::*;

	typedef struct packed {
		logic [1:0]    status;
		logic [BW-1:0] used_bytes;
		logic [BW-1:0] peak_used_bytes;
		logic [BW-1:0] pending_total;
		logic [BW-1:0] fullsync_total;
		logic [BW-1:0] client_total;
		logic [BW-1:0] client_limit_bytes;
	} quota_result_t;
endpackage

// ===== sim/tb.sv =====
// tb: testbench of sharded_memory_quota_admission. Directed and random quota events
// run against an in-bench quota predictor; each result transaction is compared in order.
// Depends on smqa_pkg, smqa_if, smqa_tb_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
	import smqa_pkg::*;
	import smqa_tb_pkg::*;

	localparam int NW = 8;
	localparam int NS = NW + 1;
	localparam longint LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	smqa_cfg_if    cfg_ch();
	smqa_item_if   ev_ch();
	smqa_result_if res_ch();

	sharded_memory_quota_admission #(.MAX_WORKERS(NW)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch), .item(ev_ch), .result(res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [BW-1:0] q_max, q_clv;
	logic [6:0]    q_wc;
	logic          q_pct;
	logic [BW-1:0] ret_q[NS], pend_q[NS], fs_q[NS], cli_q[NS];
	logic [BW-1:0] gauge_q, peak_q;
	quota_result_t expected_results[$];
	int   errors = 0;
	longint cycles = 0;
	bit   idle_on = 1'b1;

	function automatic int active_w();
		return (q_wc > NW) ? NW : int'(q_wc);
	endfunction

	function automatic logic [BW-1:0] sum_sat(input logic [BW-1:0] arr[NS]);
		logic [BW:0] t;
		t = '0;
		for (int i = 0; i <= active_w(); i++) begin
			t = t + arr[i];
			if (t > {1'b0, M48}) t = {1'b0, M48};
		end
		return t[BW-1:0];
	endfunction

	function automatic logic [BW-1:0] even_share(input logic [BW-1:0] tot, input int id,
			input int w);
		return tot / w + ((id < tot % w) ? 1 : 0);
	endfunction

	function automatic bit over_quota(input logic [BW-1:0] lim, input int s,
			input logic [BW-1:0] add);
		logic [BW-1:0] u, r, p, cap, sh, ow;
		int w;
		w = active_w();
		if (lim == 0) return 1'b0;
		if (s == 0 || w == 0) begin
			u = sum_sat(ret_q); r = sum_sat(fs_q); p = sum_sat(pend_q);
			return u >= lim || r > lim - u || p > lim - u - r || add > lim - u - r - p;
		end
		cap = even_share(lim, s - 1, w);
		sh = even_share(ret_q[0], s - 1, w);
		ow = ret_q[s]; r = fs_q[s]; p = pend_q[s];
		return sh >= cap || ow > cap - sh || r > cap - sh - ow ||
			p > cap - sh - ow - r || add > cap - sh - ow - r - p;
	endfunction

	function automatic logic [BW-1:0] client_cap();
		logic [BW-1:0] v, b;
		v = q_clv;
		if (v == 0) return '0;
		b = v;
		if (q_pct) begin
			if (v > 100) v = 100;
			b = q_max / 100 * v + q_max % 100 * v / 100;
		end
		return (b < MIN_CLIENT_BYTES) ? MIN_CLIENT_BYTES : b;
	endfunction

	function automatic bit fits(input logic [BW-1:0] cur, input logic [BW-1:0] a);
		return a <= M48 - cur;
	endfunction

	function automatic void apply_event(input item_t it);
		int w, s;
		logic [BW-1:0] a, ra, steady, cap, tot;
		logic [1:0] st;
		quota_result_t r;
		w = active_w();
		s = (it.shard >= 1 && it.shard <= w) ? int'(it.shard) : 0;
		a = it.amount; ra = it.retained_amount;
		steady = q_max - q_max / 10;
		st = ST_OK;
		case (it.kind)
			KIND_RESERVE: if (a != 0 && steady != 0) begin
				if (over_quota(steady, s, a)) st = ST_DENIED;
				else if (!fits(pend_q[s], a)) st = ST_FAULT;
				else pend_q[s] += a;
			end
			KIND_RELEASE: if (pend_q[s] < a) st = ST_FAULT; else pend_q[s] -= a;
			KIND_COMMIT: begin
				if (pend_q[s] < a || !fits(ret_q[s], ra)) st = ST_FAULT;
				else begin pend_q[s] -= a; ret_q[s] += ra; end
			end
			KIND_CHARGE: if (!fits(ret_q[s], a)) st = ST_FAULT; else ret_q[s] += a;
			KIND_UNCHARGE: if (ret_q[s] < a) st = ST_FAULT; else ret_q[s] -= a;
			KIND_FS_RSV: if (a != 0) begin
				if (over_quota(steady, s, a)) st = ST_DENIED;
				else if (!fits(fs_q[s], a)) st = ST_FAULT;
				else fs_q[s] += a;
			end
			KIND_FS_USE: begin
				if (fs_q[s] < a || !fits(ret_q[s], a)) st = ST_FAULT;
				else begin fs_q[s] -= a; ret_q[s] += a; end
			end
			KIND_FS_RST: begin
				if (ret_q[s] < a || !fits(fs_q[s], a)) st = ST_FAULT;
				else begin ret_q[s] -= a; fs_q[s] += a; end
			end
			KIND_FS_REL: if (fs_q[s] < a) st = ST_FAULT; else fs_q[s] -= a;
			KIND_CL_ACQ: if (a != 0) begin
				if (q_max != 0) begin
					if (s == 0 || w == 0) st = ST_DENIED;
					else begin
						tot = client_cap();
						if (tot != 0) begin
							cap = even_share(tot, s - 1, w);
							if (cli_q[s] > cap || a > cap - cli_q[s]) st = ST_DENIED;
						end
					end
				end
				if (st == ST_OK) begin
					if (!fits(cli_q[s], a)) st = ST_FAULT; else cli_q[s] += a;
				end
			end
			KIND_CL_REL: if (cli_q[s] < a) st = ST_FAULT; else cli_q[s] -= a;
			KIND_QUERY: st = over_quota(steady, s, a) ? ST_DENIED : ST_OK;
			KIND_REFRESH: begin
				gauge_q = sum_sat(ret_q);
				if (gauge_q > peak_q) peak_q = gauge_q;
			end
			default: ;
		endcase
		r.status = st;
		r.used_bytes = gauge_q;
		r.peak_used_bytes = peak_q;
		r.pending_total = sum_sat(pend_q);
		r.fullsync_total = sum_sat(fs_q);
		r.client_total = sum_sat(cli_q);
		r.client_limit_bytes = client_cap();
		expected_results.push_back(r);
	endfunction

	function automatic void reset_quota_state();
		q_max = '0; q_wc = 7'd1; q_clv = 48'd5; q_pct = 1'b1;
		for (int i = 0; i < NS; i++) begin
			ret_q[i] = '0; pend_q[i] = '0; fs_q[i] = '0; cli_q[i] = '0;
		end
		gauge_q = '0; peak_q = '0;
	endfunction

	function automatic bit idle_roll();
		return idle_on && ($urandom_range(99) < 22);
	endfunction

	initial begin
		cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
		ev_ch.valid = 1'b0; ev_ch.kind = '0; ev_ch.shard = '0;
		ev_ch.amount = '0; ev_ch.retained_amount = '0;
		res_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("sharded_memory_quota_admission verification failed");
			$finish;
		end
	end

	// result checker and sink stalls
	always @(posedge clk) begin
		quota_result_t exp_r, got;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.status, res_ch.used_bytes, res_ch.peak_used_bytes,
					res_ch.pending_total, res_ch.fullsync_total, res_ch.client_total,
					res_ch.client_limit_bytes};
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction %p", $time, got);
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
					end
				end
			end
			res_ch.ready <= !idle_roll();
		end
	end

	// valid stays high after an accepted transaction until the next one or an idle
	task automatic send_event(input logic [3:0] k, input logic [6:0] sh,
			input logic [BW-1:0] a, input logic [BW-1:0] ra);
		item_t it;
		while (idle_roll()) begin
			ev_ch.valid <= 1'b0;
			@(posedge clk);
		end
		it = '{k, sh, a, ra};
		ev_ch.valid <= 1'b1; ev_ch.kind <= k; ev_ch.shard <= sh;
		ev_ch.amount <= a; ev_ch.retained_amount <= ra;
		do @(posedge clk); while (!ev_ch.ready);
		apply_event(it);
	endtask

	task automatic drain();
		ev_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [BW-1:0] val);
		cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_MAX_BYTES: q_max = val;
			REG_WORKERS:   q_wc = val[6:0];
			REG_CL_VALUE:  q_clv = val;
			REG_CL_PCT:    q_pct = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [BW-1:0] mx, input logic [6:0] wc,
			input logic [BW-1:0] clv, input logic pct);
		drain();
		write_reg(REG_MAX_BYTES, mx);
		write_reg(REG_WORKERS, {41'd0, wc});
		write_reg(REG_CL_VALUE, clv);
		write_reg(REG_CL_PCT, {47'd0, pct});
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [BW-1:0] rand_amount();
		case ($urandom_range(5))
			0: return '0;
			1: return M48 - $urandom_range(3);
			2: return 48'({$urandom, $urandom});
			default: return 48'($urandom_range(200000));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_event(KIND_QUERY, 7'd0, 48'd0, 48'd0);
		send_event(KIND_CL_ACQ, 7'd1, 48'd100, 48'd0);
		send_event(KIND_REFRESH, 7'd0, 48'd0, 48'd0);
	endtask

	task automatic test_directed_events();
		set_config(48'd1000000, 7'd4, 48'd50, 1'b1);
		for (int k = 0; k < 16; k++)
			send_event(4'(k), 7'(k % 6), 48'd1000, 48'd500);
		send_event(KIND_CHARGE, 7'd1, M48, 48'd0);
		send_event(KIND_CHARGE, 7'd1, 48'd1, 48'd0);
		send_event(KIND_UNCHARGE, 7'd2, 48'd5, 48'd0);
		send_event(KIND_COMMIT, 7'd3, 48'd0, 48'd77);
		send_event(KIND_CL_ACQ, 7'd0, 48'd10, 48'd0);
		send_event(KIND_RESERVE, 7'd64, M48, 48'd0);
		send_event(KIND_REFRESH, 7'd127, 48'd0, 48'd0);
		send_event(KIND_UNCHARGE, 7'd1, M48, 48'd0);
		send_event(KIND_REFRESH, 7'd0, 48'd0, 48'd0);
	endtask

	task automatic random_phase(input int n);
		logic [3:0] k;
		logic [6:0] sh;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13))
				: 4'($urandom_range(12));
			sh = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(9));
			send_event(k, sh, rand_amount(), rand_amount());
		end
	endtask

	task automatic test_random_configs();
		set_config(M48, 7'd127, 48'd200, 1'b1);
		random_phase(250);
		set_config(48'd5000000, 7'd0, 48'd0, 1'b0);
		random_phase(150);
		idle_on = 1'b0;
		set_config(48'd3000000, 7'd8, 48'd400000, 1'b0);
		random_phase(200);
		idle_on = 1'b1;
		set_config(48'd0, 7'd3, M48, 1'b1);
		random_phase(150);
		set_config(48'd2000000, 7'd64, 48'd30, 1'b1);
		random_phase(150);
	endtask

	task automatic test_pause_until_drained();
		random_phase(10);
		ev_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		random_phase(10);
	endtask

	initial begin
		reset_quota_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_events();
		test_random_configs();
		test_pause_until_drained();
		drain();
		if (errors == 0) $display("sharded_memory_quota_admission verification clean");
		else $display("sharded_memory_quota_admission verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/smqa_pkg.sv
rtl/core/smqa_if.sv
rtl/core/smqa_div.sv
rtl/core/smqa_front.sv
rtl/core/smqa_back.sv
rtl/core/sharded_memory_quota_admission.sv
sim/smqa_tb_if.sv
sim/tb.sv
